// ===== src/decimal_multiprecision_digit_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal digit unit
// Shared property forms, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_MULTIPRECISION_DIGIT_UNIT_MACROS_SVH
`define DECIMAL_MULTIPRECISION_DIGIT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMDU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMDU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dmdu_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal digit unit package
// Command codes and controller states.
// ----------------------------------------------------------------------------
package dmdu_pkg;

    localparam int DEC_BASE = 10;

    typedef enum logic [2:0] {
        M_SET_ONE = 3'd0,
        M_DIV     = 3'd1,
        M_ADD     = 3'd2,
        M_SUB     = 3'd3,
        M_MUL     = 3'd4,
        M_SUB_AB  = 3'd5,
        M_READ    = 3'd6,
        M_CLEAR   = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// ===== src/dmdu_if.sv =====
// ----------------------------------------------------------------------------
// Decimal digit unit channels
// Command and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmdu_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [9:0] operand;
    logic       acc_select;
    logic [9:0] digit_index;

    modport source (output valid, mode, operand, acc_select, digit_index, input ready);
    modport sink   (input valid, mode, operand, acc_select, digit_index, output ready);
endinterface

interface dmdu_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit;
    logic       error;

    modport source (output valid, digit, error, input ready);
    modport sink   (input valid, digit, error, output ready);
endinterface

// ===== src/dmdu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dmdu_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/decimal_multiprecision_digit_unit.sv =====
// ----------------------------------------------------------------------------
// Decimal multiprecision digit unit
// Term and two accumulators held as rows of decimal digits in RAM.
// ----------------------------------------------------------------------------
// Each command word other than a divide by zero sweeps the rows once (a
// digit read visits only its indexed row), one digit per clock, through a
// three-stage read-modify-write pipeline (RAM read, digit multiply, carry or
// remainder update and write-back). A single carry/remainder register,
// r_chain, ripples between positions. After reset the digit RAM is zeroed
// before the first command is accepted.
// The response word is registered, so a new command may start while it waits.
module decimal_multiprecision_digit_unit
    import dmdu_pkg::*;
#(
    parameter int DIGITS       = 1024,
    parameter int OPERAND_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dmdu_cmd_if.sink  i_cmd,
    dmdu_rsp_if.source o_rsp
);

    localparam int AW    = $clog2(DIGITS);
    localparam int OB    = OPERAND_BITS;
    localparam int PW    = OB + 4;
    localparam int SH    = PW + 4;
    localparam int RW    = SH - 2;
    localparam int RECIP = (2 ** SH + DEC_BASE - 1) / DEC_BASE;

    t_state r_state, n_state;
    t_mode  r_mode;
    logic          r_sel, r_init, r_inrange, r_err;
    logic [OB-1:0] r_opnd, r_chain, n_chain;
    logic [AW-1:0] r_cnt, r_len, r_idx, w_raddr;

    logic          r_p1_v, r_p2_v;
    logic [AW-1:0] r_p1_addr, r_p2_addr;
    logic [3:0]    r_t2, r_a2, r_b2, r_rd_digit;
    logic [PW-1:0] r_prod2;

    logic       r_out_v, r_out_error;
    logic [3:0] r_out_digit;

    logic [3:0]  w_tq, w_aq, w_bq;
    logic [11:0] w_rowq, w_rowd;
    logic        w_we;
    logic        w_we_t, w_we_a, w_we_b;
    logic [3:0]  w_wdig;
    logic        w_accept, w_issue, w_load_out, w_ready;

    logic [31:0]   w_opnd32, w_idx32;
    logic [OB-1:0] w_opnd;
    t_mode         w_mode;

    assign w_opnd32 = 32'(i_cmd.operand);
    assign w_opnd   = w_opnd32[OB-1:0];
    assign w_idx32  = 32'(i_cmd.digit_index);
    assign w_mode   = t_mode'(i_cmd.mode);

    // Controller.
    always_comb begin
        n_state    = r_state;
        w_ready    = 1'b0;
        w_issue    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ready = 1'b1;
                if (i_cmd.valid) begin
                    n_state = (w_mode == M_DIV && w_opnd == '0) ? S_DONE : S_SWEEP;
                end
            end
            S_SWEEP: begin
                w_issue = 1'b1;
                if (r_cnt == r_len) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (r_init) begin
                    n_state = S_IDLE;
                end else if (!r_out_v || o_rsp.ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_accept    = w_ready && i_cmd.valid;
    assign i_cmd.ready = w_ready;

    // Divide runs from the integer digit down, a read goes straight to the indexed
    // digit, and everything else runs from the least significant digit up.
    always_comb begin
        if (r_mode == M_READ && !r_init) begin
            w_raddr = r_idx;
        end else if (r_mode == M_DIV && !r_init) begin
            w_raddr = r_cnt;
        end else begin
            w_raddr = AW'(DIGITS - 1) - r_cnt;
        end
    end

    // One RAM word holds the term digit and both accumulator digits of a
    // position; the digits that a command leaves alone are written back as read.
    assign w_we   = w_we_t || w_we_a || w_we_b;
    assign w_rowd = {w_we_t ? w_wdig : r_t2, w_we_a ? w_wdig : r_a2, w_we_b ? w_wdig : r_b2};
    assign w_tq   = w_rowq[11:8];
    assign w_aq   = w_rowq[7:4];
    assign w_bq   = w_rowq[3:0];

    dmdu_ram #(.WIDTH(12), .DEPTH(DIGITS)) u_rows (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_p2_addr), .i_wdata(w_rowd),
        .i_raddr(w_raddr), .o_rdata(w_rowq)
    );

    // Digit update stage: carry, borrow or remainder ripples through r_chain.
    always_comb begin
        logic [3:0]       dst;
        logic [4:0]       sum;
        logic [4:0]       need;
        logic [PW-1:0]    cur;
        logic [PW-1:0]    dsh;
        logic [3:0]       quo;
        logic [PW-1:0]    prd;
        logic [PW+RW-1:0] qfull;
        logic [OB-1:0]    q10;
        logic [PW-1:0]    rem10;
        dst    = r_sel ? r_b2 : r_a2;
        sum    = '0;
        need   = '0;
        cur    = '0;
        dsh    = '0;
        quo    = '0;
        prd    = '0;
        qfull  = '0;
        q10    = '0;
        rem10  = '0;
        w_we_t = 1'b0;
        w_we_a = 1'b0;
        w_we_b = 1'b0;
        w_wdig = '0;
        n_chain = r_chain;
        if (r_init) begin
            w_we_t = r_p2_v;
            w_we_a = r_p2_v;
            w_we_b = r_p2_v;
        end else begin
            case (r_mode)
                M_SET_ONE: begin
                    w_we_t = r_p2_v;
                    w_wdig = (r_p2_addr == '0) ? 4'd1 : 4'd0;
                end
                M_DIV: begin
                    cur = (PW'(r_chain) << 3) + (PW'(r_chain) << 1) + PW'(r_t2);
                    for (int k = 3; k >= 0; k--) begin
                        dsh = PW'(r_opnd) << k;
                        if (cur >= dsh) begin
                            cur    = cur - dsh;
                            quo[k] = 1'b1;
                        end
                    end
                    w_we_t  = r_p2_v;
                    w_wdig  = quo;
                    n_chain = cur[OB-1:0];
                end
                M_ADD: begin
                    sum = {1'b0, dst} + {1'b0, r_t2} + 5'(r_chain[0]);
                    n_chain = '0;
                    if (sum >= 5'(DEC_BASE)) begin
                        sum        = sum - 5'(DEC_BASE);
                        n_chain[0] = 1'b1;
                    end
                    w_wdig = sum[3:0];
                    w_we_a = r_p2_v && !r_sel;
                    w_we_b = r_p2_v && r_sel;
                end
                M_SUB, M_SUB_AB: begin
                    if (r_mode == M_SUB_AB) begin
                        dst  = r_a2;
                        need = {1'b0, r_b2} + 5'(r_chain[0]);
                    end else begin
                        need = {1'b0, r_t2} + 5'(r_chain[0]);
                    end
                    n_chain = '0;
                    if ({1'b0, dst} < need) begin
                        sum        = {1'b0, dst} + 5'(DEC_BASE) - need;
                        n_chain[0] = 1'b1;
                    end else begin
                        sum = {1'b0, dst} - need;
                    end
                    w_wdig = sum[3:0];
                    w_we_a = r_p2_v && (!r_sel || r_mode == M_SUB_AB);
                    w_we_b = r_p2_v && r_sel && r_mode == M_SUB;
                end
                M_MUL: begin
                    // Divide by ten through a reciprocal multiply.
                    prd     = r_prod2 + PW'(r_chain);
                    qfull   = (PW + RW)'(prd) * (PW + RW)'(RECIP);
                    q10     = qfull[SH +: OB];
                    rem10   = prd - ((PW'(q10) << 3) + (PW'(q10) << 1));
                    w_wdig  = rem10[3:0];
                    n_chain = q10;
                    w_we_a  = r_p2_v && !r_sel;
                    w_we_b  = r_p2_v && r_sel;
                end
                M_CLEAR: begin
                    w_we_a = r_p2_v && !r_sel;
                    w_we_b = r_p2_v && r_sel;
                end
                M_READ: begin
                    w_wdig = '0;
                end
                default: w_wdig = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_init  <= 1'b1;
            r_mode  <= M_CLEAR;
            r_cnt   <= '0;
            r_len   <= AW'(DIGITS - 1);
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_chain <= '0;
        end else begin
            r_state <= n_state;
            r_p1_v  <= w_issue;
            r_p2_v  <= r_p1_v;
            if (w_accept) begin
                r_mode  <= w_mode;
                r_cnt   <= '0;
                r_len   <= (w_mode == M_READ) ? '0 : AW'(DIGITS - 1);
                r_chain <= '0;
            end else if (w_issue && r_cnt != r_len) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_p2_v && !r_init) begin
                r_chain <= n_chain;
            end
            if (r_state == S_DONE) begin
                r_init <= 1'b0;
            end
            if (w_load_out) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sel     <= i_cmd.acc_select;
            r_opnd    <= w_opnd;
            r_idx     <= w_idx32[AW-1:0];
            r_inrange <= w_idx32 < 32'(DIGITS);
            r_err     <= (w_mode == M_DIV) && (w_opnd == '0);
        end
        r_p1_addr <= w_raddr;
        r_p2_addr <= r_p1_addr;
        r_t2      <= w_tq;
        r_a2      <= w_aq;
        r_b2      <= w_bq;
        r_prod2   <= PW'(r_sel ? w_bq : w_aq) * PW'(r_opnd);
        if (r_p2_v) begin
            r_rd_digit <= r_sel ? r_b2 : r_a2;
        end
        if (w_load_out) begin
            r_out_digit <= (r_mode == M_READ && r_inrange) ? r_rd_digit : 4'd0;
            r_out_error <= r_err;
        end
    end

    assign o_rsp.valid = r_out_v;
    assign o_rsp.digit = r_out_digit;
    assign o_rsp.error = r_out_error;

`include "decimal_multiprecision_digit_unit_macros.svh"

    `DMDU_ASSERT_SAME(a_no_write_when_ready, i_cmd.ready, !r_p2_v && !r_p1_v, "busy while idle")
    `DMDU_ASSERT_NEXT(a_busy_after_accept, i_cmd.valid && i_cmd.ready, !i_cmd.ready, "accepted twice")
    `DMDU_ASSERT_SAME(a_error_no_digit, o_rsp.valid && o_rsp.error, o_rsp.digit == 4'd0, "digit on error")

endmodule
